[rtl/chunked_body_decoder_top_macros.svh]
// Assertion macros for the chunked body decoder checker.
`ifndef CHUNKED_BODY_DECODER_TOP_MACROS_SVH
`define CHUNKED_BODY_DECODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet in reset.
`define CBD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet in reset.
`define CBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/cbd_pkg.sv]
// Shared types, constants and the byte classifier of the chunked body decoder.
package cbd_pkg;

	localparam int SIZE_BITS_DEF  = 32;
	localparam int COUNT_BITS_DEF = 32;
	localparam int BODY_LEN_W     = 32;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UF = 8'h46;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;
	localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	typedef struct packed {
		logic [7:0] raw;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_cr;
		logic       is_lf;
	} cbd_item_t;

	typedef struct packed {
		logic [7:0]            out_byte;
		logic                  out_valid;
		logic                  chunk_last;
		logic [1:0]            status;
		logic [BODY_LEN_W-1:0] body_length;
	} cbd_result_t;

	function automatic cbd_item_t classify(logic [7:0] ch);
		cbd_item_t it;
		logic      is_dec;
		logic      is_let;
		is_dec     = (ch >= CH_0) && (ch <= CH_9);
		is_let     = ((ch >= CH_LA) && (ch <= CH_LF_HEX)) || ((ch >= CH_UA) && (ch <= CH_UF));
		it.raw     = ch;
		it.is_hex  = is_dec | is_let;
		it.hex_val = is_let ? (ch[3:0] + HEX_LETTER_OFS) : ch[3:0];
		it.is_cr   = (ch == CH_CR);
		it.is_lf   = (ch == CH_LF);
		return it;
	endfunction

endpackage

[rtl/cbd_fifo.sv]
// Small register queue with push/full and pop/empty sides.
module cbd_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  T     din,
	input  logic pop,
	output logic empty,
	output T     dout
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	T              mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/cbd_front.sv]
// Front end: classifies each incoming byte and queues it for the parser.
module cbd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        in_byte,
	input  logic              take,
	output logic              item_avail,
	output cbd_pkg::cbd_item_t item
);
	import cbd_pkg::*;

	cbd_item_t cls;
	logic      q_empty;

	assign cls        = classify(in_byte);
	assign item_avail = ~q_empty;

	cbd_fifo #(
		.T     (cbd_item_t),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.din    (cls),
		.pop    (take),
		.empty  (q_empty),
		.dout   (item)
	);

endmodule

[rtl/cbd_back.sv]
// Back end: chunk parse state machine and the result queue.
module cbd_back #(
	parameter int SIZE_BITS  = cbd_pkg::SIZE_BITS_DEF,
	parameter int COUNT_BITS = cbd_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_avail,
	input  cbd_pkg::cbd_item_t              item,
	output logic                            take,
	output logic                            empty,
	input  logic                            pop,
	output logic [7:0]                      out_byte,
	output logic                            out_valid,
	output logic                            chunk_last,
	output logic [1:0]                      status,
	output logic [cbd_pkg::BODY_LEN_W-1:0]  body_length
);
	import cbd_pkg::*;

	localparam logic [3:0] PH_SIZE         = 4'd0;
	localparam logic [3:0] PH_SIZE_CR      = 4'd1;
	localparam logic [3:0] PH_DATA         = 4'd2;
	localparam logic [3:0] PH_EOL          = 4'd3;
	localparam logic [3:0] PH_EOL_CR       = 4'd4;
	localparam logic [3:0] PH_TRL_START    = 4'd5;
	localparam logic [3:0] PH_TRL_START_CR = 4'd6;
	localparam logic [3:0] PH_TRL_LINE     = 4'd7;
	localparam logic [3:0] PH_TRL_LINE_CR  = 4'd8;
	localparam logic [3:0] PH_DONE         = 4'd9;
	localparam logic [3:0] PH_ERROR        = 4'd10;

	logic [3:0]            phase_q, phase_a, phase_d;
	logic [SIZE_BITS-1:0]  acc_q, acc_a, acc_d;
	logic [SIZE_BITS-1:0]  left_q, left_a, left_d;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;
	logic [BODY_LEN_W-1:0] len_d;
	logic                  run_b;
	logic                  valid_d;
	logic                  last_d;
	logic                  res_full;
	cbd_result_t           res_d;
	cbd_result_t           res_out;

	assign take = item_avail & ~res_full;

	// First pass: line ends pending after a CR. A byte other than LF finishes
	// the line and is then handled again by the phase that follows.
	always_comb begin
		phase_a = phase_q;
		acc_a   = acc_q;
		left_a  = left_q;
		run_b   = 1'b1;
		unique case (phase_q)
			PH_SIZE_CR: begin
				acc_a   = '0;
				run_b   = ~item.is_lf;
				if (acc_q == '0) begin
					phase_a = PH_TRL_START;
				end else begin
					phase_a = PH_DATA;
					left_a  = acc_q;
				end
			end
			PH_EOL_CR: begin
				phase_a = PH_SIZE;
				run_b   = ~item.is_lf;
			end
			PH_TRL_LINE_CR: begin
				phase_a = PH_TRL_START;
				run_b   = ~item.is_lf;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		phase_d = phase_a;
		acc_d   = acc_a;
		left_d  = left_a;
		cnt_d   = cnt_q;
		valid_d = 1'b0;
		last_d  = 1'b0;
		if (run_b) begin
			unique case (phase_a)
				PH_SIZE: begin
					if (item.is_hex) begin
						if (acc_a[SIZE_BITS-1 -: 4] != 4'd0) begin
							phase_d = PH_ERROR;
						end else begin
							acc_d = {acc_a[SIZE_BITS-5:0], item.hex_val};
						end
					end else if (item.is_cr) begin
						phase_d = PH_SIZE_CR;
					end else if (item.is_lf) begin
						acc_d = '0;
						if (acc_a == '0) begin
							phase_d = PH_TRL_START;
						end else begin
							phase_d = PH_DATA;
							left_d  = acc_a;
						end
					end
				end
				PH_DATA: begin
					valid_d = 1'b1;
					cnt_d   = cnt_q + 1'b1;
					left_d  = left_a - 1'b1;
					if (left_a == SIZE_BITS'(1)) begin
						last_d  = 1'b1;
						phase_d = PH_EOL;
					end
				end
				PH_EOL: begin
					phase_d = item.is_cr ? PH_EOL_CR : PH_SIZE;
				end
				PH_TRL_START: begin
					if (item.is_cr) begin
						phase_d = PH_TRL_START_CR;
					end else if (item.is_lf) begin
						phase_d = PH_DONE;
					end else begin
						phase_d = PH_TRL_LINE;
					end
				end
				PH_TRL_START_CR: begin
					phase_d = PH_DONE;
				end
				PH_TRL_LINE: begin
					if (item.is_cr) begin
						phase_d = PH_TRL_LINE_CR;
					end else if (item.is_lf) begin
						phase_d = PH_TRL_START;
					end
				end
				// CR phases are resolved in the first pass; done and error hold
				PH_SIZE_CR, PH_EOL_CR, PH_TRL_LINE_CR, PH_DONE, PH_ERROR: begin
				end
				default: begin
					phase_d = PH_ERROR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIZE;
			acc_q   <= '0;
			left_q  <= '0;
			cnt_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			left_q  <= left_d;
			cnt_q   <= cnt_d;
		end
	end

	generate
		if (COUNT_BITS >= BODY_LEN_W) begin : g_len_trunc
			assign len_d = cnt_d[BODY_LEN_W-1:0];
		end else begin : g_len_ext
			assign len_d = {{(BODY_LEN_W-COUNT_BITS){1'b0}}, cnt_d};
		end
	endgenerate

	always_comb begin
		res_d.out_byte    = valid_d ? item.raw : 8'd0;
		res_d.out_valid   = valid_d;
		res_d.chunk_last  = last_d;
		res_d.status      = (phase_d == PH_DONE) ? ST_DONE :
		                    (phase_d == PH_ERROR) ? ST_ERR : ST_RUN;
		res_d.body_length = len_d;
	end

	cbd_fifo #(
		.T     (cbd_result_t),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (take),
		.full   (res_full),
		.din    (res_d),
		.pop    (pop),
		.empty  (empty),
		.dout   (res_out)
	);

	assign out_byte    = res_out.out_byte;
	assign out_valid   = res_out.out_valid;
	assign chunk_last  = res_out.chunk_last;
	assign status      = res_out.status;
	assign body_length = res_out.body_length;

endmodule

[rtl/chunked_body_decoder_top.sv]
// Top level of the chunked body decoder: byte classifier front, parser back.
//
//   channel   handshake         payload
//   input     push / full       in_byte
//   result    empty / pop       out_byte, out_valid, chunk_last, status, body_length
//
// One byte per cycle sustained while the result side is popped: every accepted byte gives exactly one item.
// A result shows (empty low) once its byte has passed the classified-byte queue and the
// parse state machine, which writes the result queue in the cycle that it takes the
// byte; the byte is not taken while the result queue is full.
// Both queues are two items deep; full rises only when the result side stalls.
// arst_n clears both queues and the parser; no clearing pass is needed.
module chunked_body_decoder_top #(
	parameter int SIZE_BITS  = cbd_pkg::SIZE_BITS_DEF,
	parameter int COUNT_BITS = cbd_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [7:0]                     in_byte,
	output logic                           empty,
	input  logic                           pop,
	output logic [7:0]                     out_byte,
	output logic                           out_valid,
	output logic                           chunk_last,
	output logic [1:0]                     status,
	output logic [cbd_pkg::BODY_LEN_W-1:0] body_length
);
	import cbd_pkg::*;

	cbd_item_t item;
	logic      item_avail;
	logic      take;

	cbd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_byte    (in_byte),
		.take       (take),
		.item_avail (item_avail),
		.item       (item)
	);

	cbd_back #(
		.SIZE_BITS  (SIZE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_avail  (item_avail),
		.item        (item),
		.take        (take),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.out_valid   (out_valid),
		.chunk_last  (chunk_last),
		.status      (status),
		.body_length (body_length)
	);

endmodule

[rtl/cbd_checker.sv]
// Port-level checks on the chunked body decoder, bound to its top level.
`include "chunked_body_decoder_top_macros.svh"

module cbd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       out_valid,
	input logic       chunk_last,
	input logic [1:0] status
);
	import cbd_pkg::*;

	logic taken;

	assign taken = pop && !empty;

	// payload only ever passes while the body is still being parsed
	`CBD_ASSERT_NOW(a_payload_running, !empty && out_valid, status == ST_RUN, "payload not running")
	`CBD_ASSERT_NOW(a_last_is_payload, !empty && chunk_last, out_valid, "last without payload")
	`CBD_ASSERT_NOW(a_idle_byte_zero, !empty && !out_valid, out_byte == 8'd0, "idle byte not zero")
	// completion and error are sticky until reset
	`CBD_ASSERT_NEXT(a_err_sticky, taken && status == ST_ERR, empty || status == ST_ERR, "error lost")
	`CBD_ASSERT_NEXT(a_done_sticky, taken && status == ST_DONE, empty || status == ST_DONE, "done lost")

endmodule

bind chunked_body_decoder_top cbd_checker u_cbd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.out_byte   (out_byte),
	.out_valid  (out_valid),
	.chunk_last (chunk_last),
	.status     (status)
);
